// File: rtl/olir_pkg.sv
// shared types and codes for the ordered list insert/remove unit
package olir_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_POP    = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PLACE,
		S_SHIFT_DN,
		S_POP,
		S_HOLD
	} state_t;

endpackage

// File: rtl/olir_ram.sv
// single write port, single registered read port word memory
module olir_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/ordered_list_insert_remove_unit.sv
// ordered list of signed words with append, pop, insert and remove at an index
//
//  channel  | signals                              | direction
//  request  | in_valid in_ready operation position | in
//           | value                                |
//  result   | out_valid out_ready status           | out
//           | popped_value entry_count             |
//
// append, failed requests, insert at the end and remove of the last entry finish on
// acceptance; pop ends in S_POP, insert shifts up the tail then writes in S_PLACE,
// remove shifts down the tail: the single memory write port moves one word a cycle.
// a result that cannot leave because out_ready is low parks the unit for as long.
// reset clears the count and the control state; memory contents are not cleared.
module ordered_list_insert_remove_unit
	import olir_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic [$clog2(DEPTH+1)-1:0]       position,
	input  logic signed [WORD_WIDTH-1:0]     value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic signed [WORD_WIDTH-1:0]     popped_value,
	output logic [$clog2(DEPTH+1)-1:0]       entry_count
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int AW    = $clog2(DEPTH);

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	logic [AW-1:0]         ptr_q, pos_q, stop_q;
	logic [WORD_WIDTH-1:0] val_q;
	status_t               res_status_q;
	logic [CNT_W-1:0]      res_count_q;
	logic [WORD_WIDTH-1:0] res_popped_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [CNT_W-1:0]      out_count_q;
	logic [WORD_WIDTH-1:0] out_popped_q;

	// decode of an incoming request
	status_t               acc_status;
	logic [CNT_W-1:0]      acc_count;
	state_t                acc_next;
	logic                  acc_done;
	logic                  acc_we;
	logic                  acc_re;
	logic [AW-1:0]         acc_raddr;

	logic                  in_fire;
	logic                  out_free;
	logic                  done;
	status_t               done_status;
	logic [CNT_W-1:0]      done_count;
	logic [WORD_WIDTH-1:0] done_popped;
	logic                  out_load;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [WORD_WIDTH-1:0] ram_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		acc_status = STAT_OK;
		acc_count  = count_q;
		acc_next   = S_IDLE;
		acc_done   = 1'b1;
		acc_we     = 1'b0;
		acc_re     = 1'b0;
		acc_raddr  = AW'(count_q - 1'b1);
		case (op_t'(operation))
			OP_APPEND: begin
				if (count_q == CNT_W'(DEPTH)) begin
					acc_status = STAT_FULL;
				end else begin
					acc_we    = 1'b1;
					acc_count = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					acc_status = STAT_EMPTY;
				end else begin
					acc_re    = 1'b1;
					acc_done  = 1'b0;
					acc_next  = S_POP;
					acc_count = count_q - 1'b1;
				end
			end
			OP_INSERT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					acc_status = STAT_FULL;
				end else if (position > count_q) begin
					acc_status = STAT_RANGE;
				end else if (position == count_q) begin
					acc_we    = 1'b1;
					acc_count = count_q + 1'b1;
				end else begin
					// move the tail up starting from the last entry
					acc_re    = 1'b1;
					acc_done  = 1'b0;
					acc_next  = S_SHIFT_UP;
					acc_count = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					acc_status = STAT_EMPTY;
				end else if (position >= count_q) begin
					acc_status = STAT_RANGE;
				end else if (position == count_q - 1'b1) begin
					acc_count = count_q - 1'b1;
				end else begin
					acc_re    = 1'b1;
					acc_done  = 1'b0;
					acc_next  = S_SHIFT_DN;
					acc_raddr = AW'(position + 1'b1);
					acc_count = count_q - 1'b1;
				end
			end
			default: begin
				acc_status = STAT_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (done) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_d = acc_next;
					end
				end
				S_SHIFT_UP: begin
					if (ptr_q == pos_q) begin
						state_d = S_PLACE;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_d = S_IDLE;
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	// memory control and completion
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = AW'(count_q);
		ram_wdata   = value;
		ram_re      = 1'b0;
		ram_raddr   = acc_raddr;
		done        = 1'b0;
		done_status = res_status_q;
		done_count  = res_count_q;
		done_popped = '0;
		case (state_q)
			S_IDLE: begin
				ram_we      = in_fire && acc_we;
				ram_waddr   = AW'(count_q);
				ram_re      = in_fire && acc_re;
				done        = in_fire && acc_done;
				done_status = acc_status;
				done_count  = acc_count;
			end
			S_SHIFT_UP: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + 1'b1;
				ram_wdata = ram_rdata;
				ram_re    = (ptr_q != pos_q);
				ram_raddr = ptr_q - 1'b1;
			end
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
				done      = 1'b1;
			end
			S_SHIFT_DN: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q - 1'b1;
				ram_wdata = ram_rdata;
				ram_re    = (ptr_q != stop_q);
				ram_raddr = ptr_q + 1'b1;
				done      = (ptr_q == stop_q);
			end
			S_POP: begin
				done        = 1'b1;
				done_popped = ram_rdata;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	assign out_load = (done || state_q == S_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				count_q <= acc_count;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			ptr_q <= ram_raddr;
		end
		if (in_fire) begin
			pos_q        <= AW'(position);
			stop_q       <= AW'(count_q - 1'b1);
			val_q        <= value;
			res_status_q <= acc_status;
			res_count_q  <= acc_count;
		end
		if (done) begin
			res_popped_q <= done_popped;
		end
		if (out_load) begin
			if (state_q == S_HOLD) begin
				out_status_q <= res_status_q;
				out_count_q  <= res_count_q;
				out_popped_q <= res_popped_q;
			end else begin
				out_status_q <= done_status;
				out_count_q  <= done_count;
				out_popped_q <= done_popped;
			end
		end
	end

	olir_ram #(
		.DEPTH(DEPTH),
		.WIDTH(WORD_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign entry_count  = out_count_q;
	assign popped_value = out_popped_q;

endmodule

// File: rtl/olir_checker.sv
// port-level checks for the ordered list unit, bound to the top level
module olir_checker
	import olir_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   status,
	input logic [WORD_WIDTH-1:0]        popped_value,
	input logic [$clog2(DEPTH+1)-1:0]   entry_count
);

	localparam int CNT_W = $clog2(DEPTH+1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(popped_value) && $stable(entry_count))
		else $error("result changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(DEPTH))
		else $error("count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> popped_value == '0)
		else $error("failed request returned a word");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> entry_count == CNT_W'(DEPTH))
		else $error("full reported below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> entry_count == '0)
		else $error("empty reported with entries");

endmodule

bind ordered_list_insert_remove_unit olir_checker #(
	.DEPTH(DEPTH),
	.WORD_WIDTH(WORD_WIDTH)
) u_olir_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.popped_value (popped_value),
	.entry_count  (entry_count)
);

// File: bench/tb_ordered_list_insert_remove_unit.sv
// testbench for the ordered list unit: directed and random requests checked against a list model
module tb_ordered_list_insert_remove_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import olir_pkg::*;

	localparam int DEPTH      = 64;
	localparam int WORD_WIDTH = 32;
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int POS_MAX    = (1 << CW) - 1;

	typedef enum int {
		DRIFT_GROW,
		DRIFT_SHRINK,
		DRIFT_EVEN
	} drift_t;

	class list_scoreboard;
		typedef struct {
			status_t                      st;
			logic signed [WORD_WIDTH-1:0] popped;
			logic [CW-1:0]                cnt;
		} outcome_t;

		logic signed [WORD_WIDTH-1:0] words [DEPTH];
		int unsigned                  fill;
		int unsigned                  errors;
		outcome_t                     awaited [$];

		function new();
			fill = 0;
			errors = 0;
		endfunction

		// apply one accepted request to the list copy and queue its outcome
		function void note_request(op_t op, int unsigned pos, logic signed [WORD_WIDTH-1:0] val);
			outcome_t    o;
			int unsigned i;
			o.st = STAT_OK;
			o.popped = '0;
			case (op)
			OP_APPEND: begin
				if (fill >= DEPTH) begin
					o.st = STAT_FULL;
				end else begin
					words[fill] = val;
					fill++;
				end
			end
			OP_POP: begin
				if (fill == 0) begin
					o.st = STAT_EMPTY;
				end else begin
					fill--;
					o.popped = words[fill];
				end
			end
			OP_INSERT: begin
				// full wins over a bad position
				if (fill >= DEPTH) begin
					o.st = STAT_FULL;
				end else if (pos > fill) begin
					o.st = STAT_RANGE;
				end else begin
					for (i = fill; i > pos; i--)
						words[i] = words[i - 1];
					words[pos] = val;
					fill++;
				end
			end
			default: begin
				if (fill == 0) begin
					o.st = STAT_EMPTY;
				end else if (pos >= fill) begin
					o.st = STAT_RANGE;
				end else begin
					for (i = pos; i + 1 < fill; i++)
						words[i] = words[i + 1];
					fill--;
				end
			end
			endcase
			o.cnt = CW'(fill);
			awaited.push_back(o);
		endfunction

		task log_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic signed [WORD_WIDTH-1:0] pv, logic [CW-1:0] cnt);
			outcome_t o;
			if (awaited.size() == 0) begin
				log_mismatch($sformatf("unexpected result: status %0d popped %0d count %0d",
					st, pv, cnt));
			end else begin
				o = awaited.pop_front();
				if (st !== o.st || pv !== o.popped || cnt !== o.cnt)
					log_mismatch($sformatf(
						"status %0d popped %0d count %0d, expected %s popped %0d count %0d",
						st, pv, cnt, o.st.name(), o.popped, o.cnt));
			end
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [1:0]                   operation = '0;
	logic [CW-1:0]                position = '0;
	logic signed [WORD_WIDTH-1:0] value = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [1:0]                   status;
	logic signed [WORD_WIDTH-1:0] popped_value;
	logic [CW-1:0]                entry_count;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned sent = 0;

	list_scoreboard sb = new();

	ordered_list_insert_remove_unit #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.popped_value(popped_value),
		.entry_count(entry_count)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result(status, popped_value, entry_count);
	end

	// one request: random idle gap with junk payload, then hold until accepted
	task automatic push_request(op_t op, int unsigned pos, logic signed [WORD_WIDTH-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			operation <= 2'($urandom_range(3));
			position <= CW'($urandom_range(POS_MAX));
			value <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= CW'(pos);
		value <= val;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		sb.note_request(op, pos, val);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [WORD_WIDTH-1:0] pick_word();
		case ($urandom_range(9))
		0: return {1'b1, {(WORD_WIDTH - 1){1'b0}}};
		1: return {1'b0, {(WORD_WIDTH - 1){1'b1}}};
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	// insert and remove mostly get in-range positions, some anywhere in the field; others get any
	function automatic int unsigned pick_position(op_t op);
		if ($urandom_range(99) < 15)
			return $urandom_range(POS_MAX);
		if (op == OP_INSERT)
			return $urandom_range(sb.fill);
		if (op == OP_REMOVE && sb.fill > 0)
			return $urandom_range(sb.fill - 1);
		return $urandom_range(POS_MAX);
	endfunction

	task automatic random_request(drift_t drift);
		op_t         op;
		op_t         grow_op;
		op_t         shrink_op;
		int unsigned roll;
		roll = $urandom_range(99);
		grow_op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
		shrink_op = $urandom_range(1) ? OP_POP : OP_REMOVE;
		case (drift)
		DRIFT_GROW:   op = (roll < 70) ? grow_op : shrink_op;
		DRIFT_SHRINK: op = (roll < 70) ? shrink_op : grow_op;
		default:      op = op_t'($urandom_range(3));
		endcase
		push_request(op, pick_position(op), pick_word());
	endtask

	// walk the list up to full, poke it there, then down to empty and poke again
	task automatic fill_and_drain();
		while (sb.fill < DEPTH) begin
			if ($urandom_range(1))
				push_request(OP_APPEND, $urandom_range(POS_MAX), pick_word());
			else
				push_request(OP_INSERT, $urandom_range(sb.fill), pick_word());
		end
		push_request(OP_APPEND, $urandom_range(POS_MAX), pick_word());
		push_request(OP_INSERT, $urandom_range(DEPTH), pick_word());
		push_request(OP_INSERT, POS_MAX, pick_word());
		while (sb.fill > 0) begin
			if ($urandom_range(1))
				push_request(OP_POP, $urandom_range(POS_MAX), pick_word());
			else
				push_request(OP_REMOVE, $urandom_range(sb.fill - 1), pick_word());
		end
		push_request(OP_POP, $urandom_range(POS_MAX), pick_word());
		push_request(OP_REMOVE, $urandom_range(POS_MAX), pick_word());
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned quota);
		int unsigned first;
		int unsigned seg;
		drift_t      drift;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		first = sent;
		fill_and_drain();
		while (sent - first < quota) begin
			drift = drift_t'($urandom_range(2));
			seg = $urandom_range(200, 80);
			while (seg > 0 && sent - first < quota) begin
				random_request(drift);
				seg--;
			end
		end
		settle();
	endtask

	task automatic directed_requests();
		logic signed [WORD_WIDTH-1:0] w_min;
		logic signed [WORD_WIDTH-1:0] w_max;
		w_min = {1'b1, {(WORD_WIDTH - 1){1'b0}}};
		w_max = {1'b0, {(WORD_WIDTH - 1){1'b1}}};
		push_request(OP_POP, 0, '0);
		push_request(OP_REMOVE, 0, '0);
		push_request(OP_INSERT, 1, w_max);
		push_request(OP_INSERT, 0, w_min);
		push_request(OP_APPEND, POS_MAX, w_max);
		// insert at the end behaves as append
		push_request(OP_INSERT, 2, '1);
		push_request(OP_INSERT, 1, '0);
		push_request(OP_REMOVE, 4, '1);
		push_request(OP_REMOVE, POS_MAX, '0);
		push_request(OP_INSERT, POS_MAX, w_min);
		push_request(OP_REMOVE, 3, '0);
		push_request(OP_REMOVE, 1, '0);
		push_request(OP_REMOVE, 0, '0);
		push_request(OP_POP, POS_MAX, '1);
		push_request(OP_POP, 0, '0);
		push_request(OP_APPEND, 0, w_min);
		push_request(OP_APPEND, 0, {(WORD_WIDTH / 2){2'b10}});
		push_request(OP_APPEND, 0, {(WORD_WIDTH / 2){2'b01}});
		push_request(OP_POP, 0, '0);
		push_request(OP_POP, 0, '0);
		push_request(OP_POP, 0, '0);
		push_request(OP_POP, 0, '0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_requests();
		// sender holds off here until every result is back
		settle();
		run_phase(0, 0, 470);
		run_phase(83, 0, 470);
		run_phase(0, 83, 470);
		run_phase(21, 21, 470);
		repeat (100) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.log_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#15ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: ordered_list_insert_remove_unit.f
rtl/olir_pkg.sv
rtl/olir_ram.sv
rtl/ordered_list_insert_remove_unit.sv
rtl/olir_checker.sv
bench/tb_ordered_list_insert_remove_unit.sv
